// ===== hdl/nlvba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlvba_pkg
// Shared types, codes and constants of the nested-level video memory
// bump allocator.
// ----------------------------------------------------------------------------
package nlvba_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned DIM_W    = 12;
    localparam int unsigned AREA_W   = 2 * DIM_W;
    localparam int unsigned SIZE_W   = AREA_W + 2;
    localparam int unsigned MODE_W   = 4;
    localparam int unsigned LEVEL_W  = 2;
    localparam int unsigned FMT_W    = 4;
    localparam int unsigned ERR_W    = 2;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [DATA_W-1:0] ALL_ONES      = '1;
    localparam logic [DATA_W-1:0] BASE_RESET    = 32'h0400_0000;
    localparam logic [DATA_W-1:0] CAPACITY_RESET = 32'h0020_0000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd1;

    // Command modes
    localparam logic [MODE_W-1:0] MODE_SYS_START  = 4'd0;
    localparam logic [MODE_W-1:0] MODE_SYS_END    = 4'd1;
    localparam logic [MODE_W-1:0] MODE_PROC_START = 4'd2;
    localparam logic [MODE_W-1:0] MODE_PROC_END   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_VAR_START  = 4'd4;
    localparam logic [MODE_W-1:0] MODE_VAR_END    = 4'd5;
    localparam logic [MODE_W-1:0] MODE_VAR_CLEAR  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_ALLOC      = 4'd7;
    localparam logic [MODE_W-1:0] MODE_TRY        = 4'd8;

    // Levels
    localparam logic [LEVEL_W-1:0] LVL_TERM = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_SYS  = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_PROC = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_VAR  = 2'd3;

    // Pixel formats
    localparam logic [FMT_W-1:0] FMT_5650 = 4'd0;
    localparam logic [FMT_W-1:0] FMT_5551 = 4'd1;
    localparam logic [FMT_W-1:0] FMT_4444 = 4'd2;
    localparam logic [FMT_W-1:0] FMT_8888 = 4'd3;
    localparam logic [FMT_W-1:0] FMT_T4   = 4'd4;
    localparam logic [FMT_W-1:0] FMT_T8   = 4'd5;
    localparam logic [FMT_W-1:0] FMT_T16  = 4'd6;
    localparam logic [FMT_W-1:0] FMT_T32  = 4'd7;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_LEVEL    = 2'd1;
    localparam logic [ERR_W-1:0] ERR_MISMATCH = 2'd2;
    localparam logic [ERR_W-1:0] ERR_FORMAT   = 2'd3;

    // Request word after size decode
    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [LEVEL_W-1:0] level;
        logic [SIZE_W-1:0]  size;
        logic               fmt_ok;
    } nlvba_req_t;

    // Configuration registers
    typedef struct packed {
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] capacity;
    } nlvba_cfg_t;

    // Result word
    typedef struct packed {
        logic [DATA_W-1:0] address;
        logic              fits;
        logic [DATA_W-1:0] used_bytes;
        logic [DATA_W-1:0] remain_bytes;
        logic [ERR_W-1:0]  error;
    } nlvba_rsp_t;

endpackage

// ===== hdl/nlvba_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlvba_ifs
// Valid/ready channels for allocator commands and results.
// ----------------------------------------------------------------------------
interface nlvba_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [nlvba_pkg::MODE_W-1:0]    mode;
    logic [nlvba_pkg::LEVEL_W-1:0]   level;
    logic [nlvba_pkg::DIM_W-1:0]     width;
    logic [nlvba_pkg::DIM_W-1:0]     height;
    logic [nlvba_pkg::FMT_W-1:0]     pixel_format;

    modport source (output valid, mode, level, width, height, pixel_format, input ready);
    modport sink   (input valid, mode, level, width, height, pixel_format, output ready);
endinterface

interface nlvba_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [nlvba_pkg::DATA_W-1:0]    address;
    logic                            fits;
    logic [nlvba_pkg::DATA_W-1:0]    used_bytes;
    logic [nlvba_pkg::DATA_W-1:0]    remain_bytes;
    logic [nlvba_pkg::ERR_W-1:0]     error;

    modport source (output valid, address, fits, used_bytes, remain_bytes, error, input ready);
    modport sink   (input valid, address, fits, used_bytes, remain_bytes, error, output ready);
endinterface

// ===== hdl/nested_level_vram_bump_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nested_level_vram_bump_allocator_core
// Video memory bump allocator with system, process and variable levels.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake   | word
//  --------+-----+-------------+---------------------------------------------
//  cmd     | in  | valid/ready | mode, level, width, height, pixel_format
//  rsp     | out | valid/ready | address, fits, used_bytes, remain_bytes, error
//  cfg     | in  | cfg_we      | cfg_index, cfg_data (base, capacity)
//
//  One command word per cycle while rsp does not stall; each gives one result
//  word once it is taken, through the command register (width*height multiply
//  and format decode) and then the level/offset update feeding the result
//  register. Reset clears the level to terminate and all offsets to ones,
//  and loads the base and capacity defaults. A stall on rsp backs up
//  through both registers; cmd stays ready while either has room.
// ----------------------------------------------------------------------------
module nested_level_vram_bump_allocator_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [nlvba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nlvba_pkg::DATA_W-1:0]      cfg_data,
    nlvba_cmd_if.sink                         cmd,
    nlvba_rsp_if.source                       rsp
);

    // Configuration registers
    nlvba_pkg::nlvba_cfg_t cfg_reg;
    nlvba_pkg::nlvba_cfg_t cfg_next;

    // Request word between the command register and the level logic
    logic                  req_valid;
    logic                  req_ready;
    nlvba_pkg::nlvba_req_t req;

    // Decode the register write; write only while the block is idle (the block does not enforce it)
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                nlvba_pkg::REG_BASE:     cfg_next.base     = cfg_data;
                nlvba_pkg::REG_CAPACITY: cfg_next.capacity = cfg_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base     <= nlvba_pkg::BASE_RESET;
            cfg_reg.capacity <= nlvba_pkg::CAPACITY_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Register the command and compute its byte size
    nlvba_req_stage u_req_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req_valid (req_valid),
        .req       (req),
        .req_ready (req_ready)
    );

    // Check the level, advance the offsets, build the result word
    nlvba_level_ctrl u_level_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req_valid (req_valid),
        .req       (req),
        .req_ready (req_ready),
        .rsp       (rsp)
    );

endmodule

// ===== hdl/nlvba_req_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlvba_req_stage
// Input register: takes a command word and registers it with its byte size.
// ----------------------------------------------------------------------------
module nlvba_req_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    nlvba_cmd_if.sink             cmd,
    output logic                  req_valid,
    output nlvba_pkg::nlvba_req_t req,
    input  logic                  req_ready
);

    logic                         valid_reg;
    logic                         valid_next;
    nlvba_pkg::nlvba_req_t        req_reg;
    nlvba_pkg::nlvba_req_t        req_next;
    logic [nlvba_pkg::AREA_W-1:0] area;
    logic                         load;

    assign cmd.ready = !valid_reg || req_ready;
    assign load      = cmd.valid && cmd.ready;
    assign area      = nlvba_pkg::AREA_W'(cmd.width) * nlvba_pkg::AREA_W'(cmd.height);

    always_comb
    begin
        req_next.mode   = cmd.mode;
        req_next.level  = cmd.level;
        req_next.fmt_ok = 1'b1;
        unique case (cmd.pixel_format)
            nlvba_pkg::FMT_T4:
            begin
                req_next.size = nlvba_pkg::SIZE_W'(area >> 1);
            end
            nlvba_pkg::FMT_T8:
            begin
                req_next.size = nlvba_pkg::SIZE_W'(area);
            end
            nlvba_pkg::FMT_5650, nlvba_pkg::FMT_5551,
            nlvba_pkg::FMT_4444, nlvba_pkg::FMT_T16:
            begin
                req_next.size = {1'b0, area, 1'b0};
            end
            nlvba_pkg::FMT_8888, nlvba_pkg::FMT_T32:
            begin
                req_next.size = {area, 2'b00};
            end
            default:
            begin
                req_next.size   = '0;
                req_next.fmt_ok = 1'b0;
            end
        endcase
    end

    assign valid_next = load ? 1'b1 : (req_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg <= req_next;
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

// ===== hdl/nlvba_level_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlvba_level_ctrl
// Level and offset registers; executes one request word per cycle, while
// rsp is not stalled, into the result register.
// ----------------------------------------------------------------------------
module nlvba_level_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  nlvba_pkg::nlvba_cfg_t cfg,
    input  logic                  req_valid,
    input  nlvba_pkg::nlvba_req_t req,
    output logic                  req_ready,
    nlvba_rsp_if.source           rsp
);

    logic [nlvba_pkg::LEVEL_W-1:0] level_reg,  level_next;
    logic [nlvba_pkg::DATA_W-1:0]  sys_off_reg,  sys_off_next;
    logic [nlvba_pkg::DATA_W-1:0]  proc_off_reg, proc_off_next;
    logic [nlvba_pkg::DATA_W-1:0]  var_off_reg,  var_off_next;
    logic                          out_valid_reg, out_valid_next;
    nlvba_pkg::nlvba_rsp_t         out_reg,  out_next;
    logic [nlvba_pkg::DATA_W-1:0]  cur_off;
    logic [nlvba_pkg::DATA_W-1:0]  adv_off;
    logic [nlvba_pkg::DATA_W-1:0]  used;
    logic [nlvba_pkg::ERR_W-1:0]   err;
    logic                          fire;

    assign req_ready = !out_valid_reg || rsp.ready;
    assign fire      = req_valid && req_ready;

    always_comb
    begin
        unique case (level_reg)
            nlvba_pkg::LVL_SYS:  cur_off = sys_off_reg;
            nlvba_pkg::LVL_PROC: cur_off = proc_off_reg;
            nlvba_pkg::LVL_VAR:  cur_off = var_off_reg;
            default:             cur_off = '0;
        endcase
    end

    assign adv_off = cur_off + nlvba_pkg::DATA_W'(req.size);

    always_comb
    begin
        level_next    = level_reg;
        sys_off_next  = sys_off_reg;
        proc_off_next = proc_off_reg;
        var_off_next  = var_off_reg;
        err           = nlvba_pkg::ERR_NONE;
        out_next.address = '0;
        out_next.fits    = 1'b0;
        unique case (req.mode)
            nlvba_pkg::MODE_SYS_START:
            begin
                level_next   = nlvba_pkg::LVL_SYS;
                sys_off_next = '0;
            end
            nlvba_pkg::MODE_SYS_END:
            begin
                level_next   = nlvba_pkg::LVL_TERM;
                sys_off_next = nlvba_pkg::ALL_ONES;
            end
            nlvba_pkg::MODE_PROC_START:
            begin
                if (level_reg != nlvba_pkg::LVL_SYS)
                begin
                    err = nlvba_pkg::ERR_LEVEL;
                end
                else
                begin
                    level_next    = nlvba_pkg::LVL_PROC;
                    proc_off_next = sys_off_reg;
                end
            end
            nlvba_pkg::MODE_PROC_END:
            begin
                if (level_reg != nlvba_pkg::LVL_PROC)
                begin
                    err = nlvba_pkg::ERR_LEVEL;
                end
                else
                begin
                    level_next    = nlvba_pkg::LVL_SYS;
                    proc_off_next = nlvba_pkg::ALL_ONES;
                end
            end
            nlvba_pkg::MODE_VAR_START:
            begin
                if (level_reg != nlvba_pkg::LVL_PROC)
                begin
                    err = nlvba_pkg::ERR_LEVEL;
                end
                else
                begin
                    level_next   = nlvba_pkg::LVL_VAR;
                    var_off_next = proc_off_reg;
                end
            end
            nlvba_pkg::MODE_VAR_END:
            begin
                if (level_reg != nlvba_pkg::LVL_VAR)
                begin
                    err = nlvba_pkg::ERR_LEVEL;
                end
                else
                begin
                    level_next   = nlvba_pkg::LVL_PROC;
                    var_off_next = nlvba_pkg::ALL_ONES;
                end
            end
            nlvba_pkg::MODE_VAR_CLEAR:
            begin
                priority if (level_reg == nlvba_pkg::LVL_VAR)
                begin
                    var_off_next = proc_off_reg;
                end
                else if (level_reg != nlvba_pkg::LVL_PROC)
                begin
                    err = nlvba_pkg::ERR_LEVEL;
                end
                else
                begin
                    // A clear while the process level is open is a no-op
                end
            end
            nlvba_pkg::MODE_ALLOC:
            begin
                priority if (req.level != level_reg || req.level == nlvba_pkg::LVL_TERM)
                begin
                    err = nlvba_pkg::ERR_MISMATCH;
                end
                else if (!req.fmt_ok)
                begin
                    err = nlvba_pkg::ERR_FORMAT;
                end
                else
                begin
                    out_next.address = cfg.base + cur_off;
                    unique case (level_reg)
                        nlvba_pkg::LVL_SYS:  sys_off_next  = adv_off;
                        nlvba_pkg::LVL_PROC: proc_off_next = adv_off;
                        default:             var_off_next  = adv_off;
                    endcase
                end
            end
            nlvba_pkg::MODE_TRY:
            begin
                if (!req.fmt_ok)
                begin
                    err = nlvba_pkg::ERR_FORMAT;
                end
                else
                begin
                    out_next.fits = (cfg.capacity - cur_off) >= nlvba_pkg::DATA_W'(req.size);
                end
            end
            default:
            begin
                // Query and unused codes: report only
            end
        endcase

        unique case (level_next)
            nlvba_pkg::LVL_SYS:  used = sys_off_next;
            nlvba_pkg::LVL_PROC: used = proc_off_next;
            nlvba_pkg::LVL_VAR:  used = var_off_next;
            default:             used = '0;
        endcase
        out_next.used_bytes   = used;
        out_next.remain_bytes = cfg.capacity - used;
        out_next.error        = err;
    end

    assign out_valid_next = fire ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= nlvba_pkg::LVL_TERM;
            sys_off_reg   <= nlvba_pkg::ALL_ONES;
            proc_off_reg  <= nlvba_pkg::ALL_ONES;
            var_off_reg   <= nlvba_pkg::ALL_ONES;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                level_reg    <= level_next;
                sys_off_reg  <= sys_off_next;
                proc_off_reg <= proc_off_next;
                var_off_reg  <= var_off_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.address      = out_reg.address;
    assign rsp.fits         = out_reg.fits;
    assign rsp.used_bytes   = out_reg.used_bytes;
    assign rsp.remain_bytes = out_reg.remain_bytes;
    assign rsp.error        = out_reg.error;

`ifndef ASSERT_OFF
    a_fits_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.fits |-> out_reg.error == nlvba_pkg::ERR_NONE)
        else $error("fits reported together with an error");

    a_sys_start: assert property (@(posedge clk) disable iff (!rst_n)
        fire && req.mode == nlvba_pkg::MODE_SYS_START
        |=> level_reg == nlvba_pkg::LVL_SYS && sys_off_reg == '0)
        else $error("system start did not open the system level");

    a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fire && err != nlvba_pkg::ERR_NONE
        |=> $stable(level_reg) && $stable(sys_off_reg) && $stable(proc_off_reg)
            && $stable(var_off_reg))
        else $error("state changed on a rejected request");

    a_term_sys: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg == nlvba_pkg::LVL_TERM |-> sys_off_reg == nlvba_pkg::ALL_ONES)
        else $error("system offset live while terminated");
`endif

endmodule

// ===== verif/tb_nested_level_vram_bump_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nested_level_vram_bump_allocator_core
// Self-checking bench for the nested-level video memory bump allocator.
// A short table of directed commands comes first. Random command streams
// follow, run under several base/capacity settings. Each word taken on cmd
// is predicted in the bench and checked against the rsp word, field by field.
// ----------------------------------------------------------------------------
module tb_nested_level_vram_bump_allocator_core;

    import nlvba_pkg::*;

    // Mode codes the package does not name: query, and the reserved codes
    // that behave as query.
    localparam logic [MODE_W-1:0] MODE_QUERY   = 4'd9;
    localparam logic [MODE_W-1:0] MODE_RSVD_LO = 4'd10;
    localparam logic [MODE_W-1:0] MODE_RSVD_HI = 4'd15;
    // Unknown pixel formats
    localparam logic [FMT_W-1:0]  FMT_BAD_LO   = 4'd8;
    localparam logic [FMT_W-1:0]  FMT_BAD_HI   = 4'd15;

    localparam int RANDOM_PER_PHASE = 132;
    localparam int NUM_PHASES       = 4;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int DRAIN_CYCLES     = 8;
    localparam int MAX_PRINTS       = 40;

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [LEVEL_W-1:0] level;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [FMT_W-1:0]   fmt;
        bit                 typed;   // want holds a hand-written result
        nlvba_rsp_t         want;
    } cmd_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;

    nlvba_cmd_if cmd_bus ();
    nlvba_rsp_if rsp_bus ();

    nested_level_vram_bump_allocator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_bus),
        .rsp       (rsp_bus)
    );

    // ------------------------------------------------------------------
    // Allocator mirror: level register, three offsets and the two
    // configuration registers, advanced once per accepted command word.
    // ------------------------------------------------------------------
    logic [LEVEL_W-1:0] cur_level;
    logic [DATA_W-1:0]  sys_off;
    logic [DATA_W-1:0]  proc_off;
    logic [DATA_W-1:0]  var_off;
    logic [DATA_W-1:0]  base_reg;
    logic [DATA_W-1:0]  cap_reg;

    nlvba_rsp_t owed_results[$];    // results still to come, oldest first
    cmd_row_t   plan[$];            // directed table

    int  fail_count;
    int  words_sent;
    int  words_checked;
    int  cycle_count;
    int  stall_left;
    bit  gaps_on;

    // Offset of the open level; terminate reads as zero.
    function automatic logic [DATA_W-1:0] level_offset();
        case (cur_level)
            LVL_SYS:  return sys_off;
            LVL_PROC: return proc_off;
            LVL_VAR:  return var_off;
            default:  return '0;
        endcase
    endfunction

    // Apply one command to the mirror and return the result it owes.
    function automatic nlvba_rsp_t predict_allocation(input cmd_row_t c);
        logic [DATA_W-1:0] area;
        logic [DATA_W-1:0] size;
        logic              fmt_ok;
        nlvba_rsp_t        r;
        r      = '0;
        area   = {20'd0, c.width} * {20'd0, c.height};
        fmt_ok = 1'b1;
        case (c.fmt)
            FMT_T4:                                  size = area >> 1;
            FMT_T8:                                  size = area;
            FMT_5650, FMT_5551, FMT_4444, FMT_T16:   size = area << 1;
            FMT_8888, FMT_T32:                       size = area << 2;
            default:
            begin
                size   = '0;
                fmt_ok = 1'b0;
            end
        endcase
        case (c.mode)
            MODE_SYS_START:
            begin
                cur_level = LVL_SYS;
                sys_off   = '0;
            end
            MODE_SYS_END:
            begin
                cur_level = LVL_TERM;
                sys_off   = ALL_ONES;
            end
            MODE_PROC_START:
                if (cur_level != LVL_SYS) r.error = ERR_LEVEL;
                else
                begin
                    cur_level = LVL_PROC;
                    proc_off  = sys_off;
                end
            MODE_PROC_END:
                if (cur_level != LVL_PROC) r.error = ERR_LEVEL;
                else
                begin
                    cur_level = LVL_SYS;
                    proc_off  = ALL_ONES;
                end
            MODE_VAR_START:
                if (cur_level != LVL_PROC) r.error = ERR_LEVEL;
                else
                begin
                    cur_level = LVL_VAR;
                    var_off   = proc_off;
                end
            MODE_VAR_END:
                if (cur_level != LVL_VAR) r.error = ERR_LEVEL;
                else
                begin
                    cur_level = LVL_PROC;
                    var_off   = ALL_ONES;
                end
            MODE_VAR_CLEAR:
                // accepted silently in process level
                if (cur_level == LVL_VAR) var_off = proc_off;
                else if (cur_level != LVL_PROC) r.error = ERR_LEVEL;
            MODE_ALLOC:
                if (c.level != cur_level || c.level == LVL_TERM) r.error = ERR_MISMATCH;
                else if (!fmt_ok) r.error = ERR_FORMAT;
                else
                begin
                    r.address = base_reg + level_offset();
                    case (cur_level)
                        LVL_SYS:  sys_off  = sys_off + size;
                        LVL_PROC: proc_off = proc_off + size;
                        LVL_VAR:  var_off  = var_off + size;
                        default:  ;
                    endcase
                end
            MODE_TRY:
                if (!fmt_ok) r.error = ERR_FORMAT;
                else r.fits = ((cap_reg - level_offset()) >= size);
            default:
                ;
        endcase
        r.used_bytes   = level_offset();
        r.remain_bytes = cap_reg - r.used_bytes;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        if (fail_count < MAX_PRINTS)
            $display("[%0t] ERROR %s: got 0x%08h, want 0x%08h", $time, what, got, want);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------
    task automatic plan_row(input logic [MODE_W-1:0] mode, input logic [LEVEL_W-1:0] lvl,
                            input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                            input logic [FMT_W-1:0] fmt);
        cmd_row_t row;
        row        = '{default: '0};
        row.mode   = mode;
        row.level  = lvl;
        row.width  = w;
        row.height = h;
        row.fmt    = fmt;
        plan.push_back(row);
    endtask

    // Row with the result written out by hand; fits is zero in all of them.
    task automatic plan_fixed(input logic [MODE_W-1:0] mode, input logic [LEVEL_W-1:0] lvl,
                              input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                              input logic [FMT_W-1:0] fmt, input logic [DATA_W-1:0] addr,
                              input logic [DATA_W-1:0] used, input logic [DATA_W-1:0] remain,
                              input logic [ERR_W-1:0] err);
        cmd_row_t row;
        row                   = '{default: '0};
        row.mode              = mode;
        row.level             = lvl;
        row.width             = w;
        row.height            = h;
        row.fmt               = fmt;
        row.typed             = 1'b1;
        row.want              = '0;
        row.want.address      = addr;
        row.want.used_bytes   = used;
        row.want.remain_bytes = remain;
        row.want.error        = err;
        plan.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Drive one command word; hold it until taken, then log what it owes.
    // valid stays high afterwards so back-to-back words follow without a gap.
    // ------------------------------------------------------------------
    task automatic send_word(input cmd_row_t c);
        nlvba_rsp_t predicted;
        @(negedge clk);
        cmd_bus.valid        <= 1'b1;
        cmd_bus.mode         <= c.mode;
        cmd_bus.level        <= c.level;
        cmd_bus.width        <= c.width;
        cmd_bus.height       <= c.height;
        cmd_bus.pixel_format <= c.fmt;
        do @(posedge clk); while (!cmd_bus.ready);
        predicted = predict_allocation(c);
        owed_results.push_back(c.typed ? c.want : predicted);
        words_sent++;
    endtask

    // Random source gap: now and then drop valid before the next word.
    task automatic maybe_gap();
        int n;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 12);
            @(negedge clk);
            cmd_bus.valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Park the source and wait until every owed result is back.
    task automatic drain();
        @(negedge clk);
        cmd_bus.valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge clk);
    endtask

    // Register write: one cycle of cfg_we, mirrored at once.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_BASE) base_reg = val;
        else cap_reg = val;
    endtask

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("cycle limit reached with %0d results owed", owed_results.size());
            $display("nested_level_vram_bump_allocator_core: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: stall in random bursts, none while gaps_on is clear.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
        end
        else if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            rsp_bus.ready <= 1'b0;
            stall_left = $urandom_range(1, 12) - 1;
        end
        else
            rsp_bus.ready <= 1'b1;
    end

    // Check every result word taken against the oldest owed one.
    always @(posedge clk)
    begin
        nlvba_rsp_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (owed_results.size() == 0)
                report_mismatch("result with nothing owed, address", rsp_bus.address, '0);
            else
            begin
                want = owed_results.pop_front();
                words_checked++;
                if (rsp_bus.address !== want.address)
                    report_mismatch("address", rsp_bus.address, want.address);
                if (rsp_bus.fits !== want.fits)
                    report_mismatch("fits", {31'd0, rsp_bus.fits}, {31'd0, want.fits});
                if (rsp_bus.used_bytes !== want.used_bytes)
                    report_mismatch("used_bytes", rsp_bus.used_bytes, want.used_bytes);
                if (rsp_bus.remain_bytes !== want.remain_bytes)
                    report_mismatch("remain_bytes", rsp_bus.remain_bytes, want.remain_bytes);
                if (rsp_bus.error !== want.error)
                    report_mismatch("error", {30'd0, rsp_bus.error}, {30'd0, want.error});
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        cmd_row_t word;
        int       pick;
        int       phase;
        int       i;

        // known values everywhere from time zero
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        cmd_bus.valid        = 1'b0;
        cmd_bus.mode         = '0;
        cmd_bus.level        = '0;
        cmd_bus.width        = '0;
        cmd_bus.height       = '0;
        cmd_bus.pixel_format = '0;
        rsp_bus.ready        = 1'b0;
        fail_count           = 0;
        words_sent           = 0;
        words_checked        = 0;
        cycle_count          = 0;
        stall_left           = 0;
        gaps_on              = 1'b1;

        // mirror of the reset state
        cur_level = LVL_TERM;
        sys_off   = ALL_ONES;
        proc_off  = ALL_ONES;
        var_off   = ALL_ONES;
        base_reg  = BASE_RESET;
        cap_reg   = CAPACITY_RESET;

        // Directed table. Terminate level first: everything but system
        // start is refused or reads as an empty level.
        plan_fixed(MODE_QUERY, LVL_TERM, 12'd0, 12'd0, FMT_5650, 0, 0, CAPACITY_RESET,
                   ERR_NONE);
        plan_fixed(MODE_ALLOC, LVL_TERM, 12'd5, 12'd5, FMT_T8, 0, 0, CAPACITY_RESET,
                   ERR_MISMATCH);
        plan_fixed(MODE_PROC_START, LVL_TERM, 12'd0, 12'd0, FMT_5650, 0, 0, CAPACITY_RESET,
                   ERR_LEVEL);
        plan_fixed(MODE_VAR_CLEAR, LVL_TERM, 12'd0, 12'd0, FMT_5650, 0, 0, CAPACITY_RESET,
                   ERR_LEVEL);
        plan_fixed(MODE_VAR_END, LVL_TERM, 12'd0, 12'd0, FMT_5650, 0, 0, CAPACITY_RESET,
                   ERR_LEVEL);
        // try in terminate measures from offset zero
        plan_row(MODE_TRY, LVL_TERM, 12'hFFF, 12'hFFF, FMT_8888);
        plan_fixed(MODE_TRY, LVL_TERM, 12'd1, 12'd1, FMT_BAD_HI, 0, 0, CAPACITY_RESET,
                   ERR_FORMAT);
        // open system level, zero-size allocation returns the bare base
        plan_fixed(MODE_SYS_START, LVL_TERM, 12'd0, 12'd0, FMT_5650, 0, 0, CAPACITY_RESET,
                   ERR_NONE);
        plan_fixed(MODE_ALLOC, LVL_SYS, 12'd0, 12'd0, FMT_5650,
                   BASE_RESET, 0, CAPACITY_RESET, ERR_NONE);
        plan_row(MODE_ALLOC, LVL_SYS, 12'hFFF, 12'hFFF, FMT_T32);
        plan_row(MODE_ALLOC, LVL_PROC, 12'd3, 12'd3, FMT_T8);
        plan_row(MODE_PROC_START, LVL_TERM, 12'd0, 12'd0, FMT_5650);
        plan_row(MODE_ALLOC, LVL_PROC, 12'd100, 12'd3, FMT_4444);
        plan_row(MODE_VAR_START, LVL_TERM, 12'd0, 12'd0, FMT_5650);
        // odd area in T4 rounds down
        plan_row(MODE_ALLOC, LVL_VAR, 12'hFFF, 12'd1, FMT_T4);
        plan_row(MODE_ALLOC, LVL_VAR, 12'd7, 12'd9, FMT_T8);
        plan_row(MODE_ALLOC, LVL_VAR, 12'd2, 12'd2, FMT_BAD_LO);
        plan_row(MODE_ALLOC, LVL_VAR, 12'hFFF, 12'd2, FMT_5551);
        plan_row(MODE_TRY, LVL_VAR, 12'd1, 12'd1, FMT_T16);
        plan_row(MODE_VAR_CLEAR, LVL_VAR, 12'd0, 12'd0, FMT_5650);
        plan_row(MODE_VAR_END, LVL_VAR, 12'd0, 12'd0, FMT_5650);
        // clear in process level is accepted and changes nothing
        plan_row(MODE_VAR_CLEAR, LVL_PROC, 12'd0, 12'd0, FMT_5650);
        plan_row(MODE_PROC_END, LVL_PROC, 12'd0, 12'd0, FMT_5650);
        // reserved modes act as query
        plan_row(MODE_RSVD_LO, LVL_SYS, 12'd1, 12'd1, FMT_T32);
        plan_row(MODE_RSVD_HI, LVL_VAR, 12'hFFF, 12'hFFF, FMT_BAD_HI);
        plan_row(MODE_SYS_END, LVL_SYS, 12'd0, 12'd0, FMT_5650);
        plan_fixed(MODE_SYS_END, LVL_TERM, 12'd0, 12'd0, FMT_5650, 0, 0, CAPACITY_RESET,
                   ERR_NONE);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[k])
        begin
            maybe_gap();
            send_word(plan[k]);
        end

        // Random phases, each under its own base/capacity setting.
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    write_reg(REG_BASE, BASE_RESET);
                    write_reg(REG_CAPACITY, CAPACITY_RESET);
                end
                1:
                begin
                    write_reg(REG_BASE, '0);
                    write_reg(REG_CAPACITY, '0);
                end
                2:
                begin
                    write_reg(REG_BASE, ALL_ONES);
                    write_reg(REG_CAPACITY, ALL_ONES);
                end
                default:
                begin
                    write_reg(REG_BASE, $urandom);
                    write_reg(REG_CAPACITY, $urandom_range(0, 32'h0040_0000));
                    gaps_on = 1'b0;     // last stretch runs at full rate
                end
            endcase

            for (i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                word       = '{default: '0};
                pick       = $urandom_range(0, 99);
                word.width  = ($urandom_range(0, 6) == 0) ? DIM_W'($urandom_range(0, 4095))
                                                          : DIM_W'($urandom_range(0, 31));
                word.height = ($urandom_range(0, 6) == 0) ? DIM_W'($urandom_range(0, 4095))
                                                          : DIM_W'($urandom_range(0, 31));
                word.fmt    = ($urandom_range(0, 9) == 0) ? FMT_W'($urandom_range(0, 15))
                                                          : FMT_W'($urandom_range(0, 7));
                word.level  = cur_level;
                if (pick < 10)
                begin
                    // noise: any field, any value
                    word.mode   = MODE_W'($urandom_range(0, 15));
                    word.level  = LEVEL_W'($urandom_range(0, 3));
                    word.width  = DIM_W'($urandom_range(0, 4095));
                    word.height = DIM_W'($urandom_range(0, 4095));
                    word.fmt    = FMT_W'($urandom_range(0, 15));
                end
                else if (pick < 27)
                begin
                    // legal walk through the levels
                    case (cur_level)
                        LVL_TERM:
                            word.mode = MODE_SYS_START;
                        LVL_SYS:
                            case ($urandom_range(0, 5))
                                0:       word.mode = MODE_SYS_END;
                                1:       word.mode = MODE_SYS_START;
                                default: word.mode = MODE_PROC_START;
                            endcase
                        LVL_PROC:
                            case ($urandom_range(0, 4))
                                0:       word.mode = MODE_PROC_END;
                                1:       word.mode = MODE_VAR_CLEAR;
                                default: word.mode = MODE_VAR_START;
                            endcase
                        default:
                            case ($urandom_range(0, 5))
                                0:       word.mode = MODE_SYS_END;
                                1, 2:    word.mode = MODE_VAR_CLEAR;
                                default: word.mode = MODE_VAR_END;
                            endcase
                    endcase
                end
                else if (pick < 78)
                    word.mode = MODE_ALLOC;
                else if (pick < 95)
                    word.mode = MODE_TRY;
                else
                    word.mode = MODE_QUERY;
                maybe_gap();
                send_word(word);
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (owed_results.size() != 0)
            report_mismatch("results never returned", owed_results.size(), 0);

        $display("%0d command words sent, %0d results checked, %0d errors",
                 words_sent, words_checked, fail_count);
        $display("settings run: reset default, zero, all ones, random base/capacity");
        if (fail_count == 0)
            $display("nested_level_vram_bump_allocator_core: match");
        else
            $display("nested_level_vram_bump_allocator_core: mismatch");
        $finish;
    end

endmodule

// ===== nested_level_vram_bump_allocator_core.f =====
hdl/nlvba_pkg.sv
hdl/nlvba_ifs.sv
hdl/nlvba_req_stage.sv
hdl/nlvba_level_ctrl.sv
hdl/nested_level_vram_bump_allocator_core.sv
verif/tb_nested_level_vram_bump_allocator_core.sv
